// File: rtl/cjs_pkg.sv
package cjs_pkg;

	localparam int MaxJobsDefault = 16;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_SELECT = 2'd1;
	localparam logic [1:0] OP_BURST  = 2'd2;

	localparam logic [2:0] POL_FCFS = 3'd0;
	localparam logic [2:0] POL_RR   = 3'd1;
	localparam logic [2:0] POL_SJF  = 3'd2;
	localparam logic [2:0] POL_LJF  = 3'd3;
	localparam logic [2:0] POL_SRTF = 3'd4;
	localparam logic [2:0] POL_LRTF = 3'd5;

	// Scan key and comparison sense, decided by the controller.
	localparam logic [1:0] KEY_ARRIVAL = 2'd0;
	localparam logic [1:0] KEY_NEED    = 2'd1;
	localparam logic [1:0] KEY_REMAIN  = 2'd2;

	typedef struct packed {
		logic       clear_best;   // start a search scan at entry 0
		logic       scan_step;    // compare entry at scan pointer
		logic [1:0] key;
		logic       largest;
		logic       take_best;    // current <= best
		logic       rr_step;      // round robin advance
		logic       clear_cur;    // no current job
		logic       append;       // write new job at count
		logic       burst_sub;    // subtract burst from current
		logic       shift_step;   // entry[ptr] <= entry[ptr+1]
		logic       shift_start;  // ptr <= current index
		logic       dec_count;
		logic       load_result;
		logic       fin;
		logic       drop;
		logic       nojob;
	} cjs_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic cur_present;
		logic cur_in_range;
		logic burst_done;     // duration >= remaining of current
		logic scan_last;      // scan pointer at last live entry
		logic shift_last;     // shift pointer reached count-1
	} cjs_stat_t;

endpackage

// File: rtl/cjs_datapath.sv
module cjs_datapath #(
	parameter int MAX_JOBS = cjs_pkg::MaxJobsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cjs_pkg::cjs_cmd_t  cmd,
	output cjs_pkg::cjs_stat_t stat,
	input  logic [31:0]        in_arrival,
	input  logic [23:0]        in_duration,
	output logic [15:0]        res_id,
	output logic               res_valid,
	output logic               res_finished,
	output logic [23:0]        res_remaining,
	output logic               res_empty,
	output logic               res_dropped,
	output logic               res_nojob
);
	import cjs_pkg::*;

	localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);

	logic [15:0] id_q     [MAX_JOBS];
	logic [31:0] arr_q    [MAX_JOBS];
	logic [23:0] need_q   [MAX_JOBS];
	logic [23:0] rem_q    [MAX_JOBS];

	logic [CW-1:0] count_q;
	logic [IW-1:0] cur_q;
	logic          present_q;
	logic [15:0]   next_id_q;
	logic [IW-1:0] ptr_q;
	logic [IW-1:0] best_q;
	logic [31:0]   best_key_q;

	logic [31:0] scan_key;
	logic        better;
	logic [IW:0] ptr_next;
	logic [IW-1:0] ptr_p1;
	logic [CW-1:0] cur_ext;

	assign ptr_p1  = ptr_q + 1'b1;
	assign ptr_next = {1'b0, ptr_q} + 1'b1;
	assign cur_ext = CW'(cur_q);

	always_comb begin
		unique case (cmd.key)
			KEY_ARRIVAL: scan_key = arr_q[ptr_q];
			KEY_NEED:    scan_key = {8'd0, need_q[ptr_q]};
			default:     scan_key = {8'd0, rem_q[ptr_q]};
		endcase
		better = cmd.largest ? (scan_key > best_key_q) : (scan_key < best_key_q);
	end

	assign stat.full         = (count_q == CW'(MAX_JOBS));
	assign stat.empty        = (count_q == '0);
	assign stat.cur_present  = present_q;
	assign stat.cur_in_range = (cur_ext < count_q);
	assign stat.burst_done   = (in_duration >= rem_q[cur_q]);
	assign stat.scan_last    = (CW'(ptr_next) >= count_q);
	assign stat.shift_last   = (CW'(ptr_next) >= count_q);

	// Table storage: append, shift up, burst update.
	always_ff @(posedge clk) begin
		if (cmd.append && !stat.full) begin
			id_q[count_q[IW-1:0]]   <= next_id_q;
			arr_q[count_q[IW-1:0]]  <= in_arrival;
			need_q[count_q[IW-1:0]] <= in_duration;
			rem_q[count_q[IW-1:0]]  <= in_duration;
		end
		if (cmd.burst_sub)
			rem_q[cur_q] <= rem_q[cur_q] - in_duration;
		if (cmd.shift_step && !stat.shift_last) begin
			id_q[ptr_q]   <= id_q[ptr_p1];
			arr_q[ptr_q]  <= arr_q[ptr_p1];
			need_q[ptr_q] <= need_q[ptr_p1];
			rem_q[ptr_q]  <= rem_q[ptr_p1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			cur_q     <= '0;
			present_q <= 1'b0;
			next_id_q <= '0;
			ptr_q     <= '0;
			best_q    <= '0;
			best_key_q <= '0;
		end else begin
			if (cmd.append && !stat.full) begin
				count_q   <= count_q + 1'b1;
				next_id_q <= next_id_q + 1'b1;
				if (stat.empty) begin
					cur_q     <= '0;
					present_q <= 1'b1;
				end
			end
			if (cmd.clear_best) begin
				ptr_q  <= '0;
				best_q <= '0;
				unique case (cmd.key)
					KEY_ARRIVAL: best_key_q <= arr_q[0];
					KEY_NEED:    best_key_q <= {8'd0, need_q[0]};
					default:     best_key_q <= {8'd0, rem_q[0]};
				endcase
			end
			if (cmd.scan_step) begin
				if (better) begin
					best_q     <= ptr_q;
					best_key_q <= scan_key;
				end
				ptr_q <= ptr_p1;
			end
			if (cmd.take_best) begin
				cur_q     <= best_q;
				present_q <= 1'b1;
			end
			if (cmd.rr_step) begin
				present_q <= 1'b1;
				if (!present_q || CW'({1'b0, cur_q} + 1'b1) >= count_q)
					cur_q <= '0;
				else
					cur_q <= cur_q + 1'b1;
			end
			if (cmd.shift_start)
				ptr_q <= cur_q;
			if (cmd.shift_step)
				ptr_q <= ptr_p1;
			if (cmd.dec_count)
				count_q <= count_q - 1'b1;
			if (cmd.clear_cur) begin
				present_q <= 1'b0;
				cur_q     <= '0;
			end
		end
	end

	// Result register, loaded when the item completes.
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			if (present_q && stat.cur_in_range) begin
				res_id        <= id_q[cur_q];
				res_valid     <= 1'b1;
				res_remaining <= rem_q[cur_q];
			end else begin
				res_id        <= '0;
				res_valid     <= 1'b0;
				res_remaining <= '0;
			end
			res_finished <= cmd.fin;
			res_empty    <= stat.empty;
			res_dropped  <= cmd.drop;
			res_nojob    <= cmd.nojob;
		end
	end

endmodule

// File: rtl/cjs_ctrl.sv
module cjs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [1:0]         item_op,
	input  logic [2:0]         policy,
	input  cjs_pkg::cjs_stat_t stat,
	output cjs_pkg::cjs_cmd_t  cmd,
	output logic               res_valid,
	input  logic               res_ready
);
	import cjs_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_SHIFT  = 3'd2;
	localparam logic [2:0] ST_RESULT = 3'd3;
	localparam logic [2:0] ST_FIN    = 3'd4;

	logic [2:0] state_q, state_d;
	logic       fin_q, fin_d, drop_q, drop_d, nojob_q, nojob_d;
	logic       out_valid_q;
	logic [1:0] key;
	logic       largest;
	logic       search;

	// The item waits in IDLE only for the result register to be free.
	assign item_ready = (state_q == ST_IDLE) && (!out_valid_q || res_ready);
	assign res_valid  = out_valid_q;

	always_comb begin
		key     = KEY_ARRIVAL;
		largest = 1'b0;
		search  = 1'b0;
		unique case (policy)
			POL_FCFS: search = 1'b1;
			POL_SJF: begin key = KEY_NEED; search = !stat.cur_present; end
			POL_LJF: begin
				key = KEY_NEED; largest = 1'b1; search = !stat.cur_present;
			end
			POL_SRTF: begin key = KEY_REMAIN; search = 1'b1; end
			POL_LRTF: begin key = KEY_REMAIN; largest = 1'b1; search = 1'b1; end
			default: search = 1'b0;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.key     = key;
		cmd.largest = largest;
		state_d     = state_q;
		fin_d       = fin_q;
		drop_d      = drop_q;
		nojob_d     = nojob_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && item_ready) begin
					fin_d = 1'b0; drop_d = 1'b0; nojob_d = 1'b0;
					state_d = ST_RESULT;
					priority if (item_op == OP_ADD) begin
						cmd.append = 1'b1;
						drop_d     = stat.full;
					end else if (item_op == OP_SELECT) begin
						priority if (stat.empty)
							cmd.clear_cur = 1'b1;
						else if (policy == POL_RR)
							cmd.rr_step = 1'b1;
						else if (search) begin
							cmd.clear_best = 1'b1;
							state_d = ST_SCAN;
						end else begin
							// hold the current job
						end
					end else if (item_op == OP_BURST) begin
						priority if (!stat.cur_present || !stat.cur_in_range)
							nojob_d = 1'b1;
						else if (stat.burst_done) begin
							cmd.shift_start = 1'b1;
							fin_d   = 1'b1;
							state_d = ST_SHIFT;
						end else
							cmd.burst_sub = 1'b1;
					end else begin
						// unknown opcode: report status only
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.take_best = 1'b1;
				state_d = ST_RESULT;
			end
			ST_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (stat.shift_last) begin
					cmd.dec_count = 1'b1;
					cmd.clear_cur = 1'b1;
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				cmd.load_result = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		cmd.fin   = fin_q;
		cmd.drop  = drop_q;
		cmd.nojob = nojob_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fin_q       <= 1'b0;
			drop_q      <= 1'b0;
			nojob_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fin_q   <= fin_d;
			drop_q  <= drop_d;
			nojob_q <= nojob_d;
			if (state_q == ST_RESULT)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/cpu_job_scheduler.sv
// Channel  | Direction | Handshake                       | Payload
// s_axis   | in        | s_axis_tvalid / s_axis_tready   | opcode, arrival_time, duration
// m_axis   | out       | m_axis_tvalid / m_axis_tready   | job status
// cfg      | in        | cfg_valid / cfg_ready           | policy
// Add, round robin and short bursts go from IDLE straight to RESULT; a searching select
// passes through SCAN, one table entry per cycle through the key comparator, then FIN;
// a finishing burst passes through SHIFT, shifting one entry per cycle, before RESULT.
// Reset clears the job count, current job and id counter; table contents stay
// undefined until written. A stalled result holds in the output register and the
// next item waits until it is taken.
module cpu_job_scheduler #(
	parameter int MAX_JOBS = cjs_pkg::MaxJobsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // opcode[1:0], arrival_time[33:2], duration[57:34]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // job_id, job_valid, job_finished, remaining,
	                                   // queue_empty, dropped_full, no_job_error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data
);
	import cjs_pkg::*;

	cjs_cmd_t  cmd;
	cjs_stat_t stat;
	logic [2:0] policy_q;

	logic [15:0] r_id;
	logic        r_valid, r_fin, r_empty, r_drop, r_nojob;
	logic [23:0] r_rem;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			policy_q <= POL_FCFS;
		else if (cfg_valid)
			policy_q <= cfg_data;
	end

	cjs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_axis_tvalid),
		.item_ready (s_axis_tready),
		.item_op    (s_axis_tdata[1:0]),
		.policy     (policy_q),
		.stat       (stat),
		.cmd        (cmd),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready)
	);

	cjs_datapath #(.MAX_JOBS(MAX_JOBS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_arrival    (s_axis_tdata[33:2]),
		.in_duration   (s_axis_tdata[57:34]),
		.res_id        (r_id),
		.res_valid     (r_valid),
		.res_finished  (r_fin),
		.res_remaining (r_rem),
		.res_empty     (r_empty),
		.res_dropped   (r_drop),
		.res_nojob     (r_nojob)
	);

	assign m_axis_tdata = {3'd0, r_nojob, r_drop, r_empty, r_rem, r_fin, r_valid, r_id};

endmodule

// File: rtl/cjs_checker.sv
module cjs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");
	ap_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'd0 &&
		m_axis_tdata[41:18] == 24'd0)
		else $error("id shown without a current job");
	ap_fin: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[17] |-> !m_axis_tdata[16])
		else $error("finished job still current");
	ap_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("two items taken back to back");
endmodule

bind cpu_job_scheduler cjs_checker u_cjs_checker (.*);
